/* hdl/lru_page_frame_mapper_core_macros.svh */
// Assertion macros for the LRU page frame mapper.
// Used by the datapath; no other dependencies.
`ifndef LRU_PAGE_FRAME_MAPPER_CORE_MACROS_SVH
`define LRU_PAGE_FRAME_MAPPER_CORE_MACROS_SVH

// Concurrent property check, disabled while in reset.
`define LPFM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next cycle.
`define LPFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lpfm_pkg.sv */
// Shared types and constants for the LRU page frame mapper.
// No dependencies.
`timescale 1ns / 1ps

package lpfm_pkg;

	localparam int MAX_FRAMES_DEF = 4;
	localparam int PAGE_BITS_DEF  = 20;

	localparam int LPAGE_W       = 20;
	localparam int ADDR_W        = 20;
	localparam int FCNT_W        = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 20;
	localparam int NUM_ADDR_REGS = 4;
	localparam int FA_IW         = 2;

	localparam logic [FCNT_W-1:0] FCNT_RESET = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ADDR_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ADDR_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ADDR_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ADDR_3 = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_cmd_t;

endpackage

/* hdl/lru_page_frame_mapper_core.sv */
// Top level of the LRU page frame mapper: controller plus datapath.
// Depends on lpfm_pkg, lpfm_ctrl, lpfm_dpath.
//
//  channel   strobe / handshake     payload
//  input     start && !busy         logical_page
//  result    done (one cycle)       phys_frame, was_hit
//  config    cfg_we                 cfg_index, cfg_wdata
//
// A new item is refused while busy: the search against all resident entries is done in the
// accept cycle and registered; the reorder and result register load follow in
// the next cycle. done pulses the cycle after, when a new item may already be taken.
// Reset clears occupancy and loads the config defaults; no clearing pass.
// done cannot be stalled.
`timescale 1ns / 1ps

module lru_page_frame_mapper_core
	import lpfm_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [LPAGE_W-1:0]    logical_page,
	output logic                  done,
	output logic [ADDR_W-1:0]     phys_frame,
	output logic                  was_hit,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ctl_cmd_t cmd;

	lpfm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lpfm_dpath #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.logical_page (logical_page),
		.done         (done),
		.phys_frame   (phys_frame),
		.was_hit      (was_hit)
	);

endmodule

/* hdl/lpfm_ctrl.sv */
// Controller for the LRU page frame mapper: capture / commit sequencing.
// Depends on lpfm_pkg.
`timescale 1ns / 1ps

module lpfm_ctrl
	import lpfm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = start;
				if (start) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				busy       = 1'b1;
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/lpfm_dpath.sv */
// Datapath for the LRU page frame mapper: config registers, resident list,
// match search, LRU reorder and result register. Depends on lpfm_pkg and the macros header.
`timescale 1ns / 1ps
`include "lru_page_frame_mapper_core_macros.svh"

module lpfm_dpath
	import lpfm_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [LPAGE_W-1:0]    logical_page,
	output logic                  done,
	output logic [ADDR_W-1:0]     phys_frame,
	output logic                  was_hit
);

	localparam int PW = (PAGE_BITS < LPAGE_W) ? PAGE_BITS : LPAGE_W;
	localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int OW = $clog2(MAX_FRAMES + 1);

	logic [FCNT_W-1:0] fcnt_q;
	logic [ADDR_W-1:0] faddr_q [NUM_ADDR_REGS];

	logic [PW-1:0]         page_q;
	logic [MAX_FRAMES-1:0] match_s1;
	logic [MAX_FRAMES-1:0] match_d;
	logic [PW-1:0]         rpage_q  [MAX_FRAMES];
	logic [ADDR_W-1:0]     rframe_q [MAX_FRAMES];
	logic [OW-1:0]         occ_q;

	logic              done_q;
	logic [ADDR_W-1:0] frame_q;
	logic              hit_q;

	logic [OW-1:0]     cap;
	logic              hit;
	logic              room;
	logic              rotate;
	logic [IW-1:0]     pos;
	logic [IW-1:0]     shift_from;
	logic [OW-1:0]     last;
	logic [ADDR_W-1:0] new_frame;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= FCNT_RESET;
			for (int k = 0; k < NUM_ADDR_REGS; k++) begin
				faddr_q[k] <= ADDR_W'(k);
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_COUNT:  fcnt_q     <= cfg_wdata[FCNT_W-1:0];
				REG_FRAME_ADDR_0: faddr_q[0] <= cfg_wdata;
				REG_FRAME_ADDR_1: faddr_q[1] <= cfg_wdata;
				REG_FRAME_ADDR_2: faddr_q[2] <= cfg_wdata;
				REG_FRAME_ADDR_3: faddr_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective capacity: zero counts as one, saturate at MAX_FRAMES
	always_comb begin
		if (fcnt_q == '0) begin
			cap = OW'(1);
		end else if (int'(fcnt_q) > MAX_FRAMES) begin
			cap = OW'(MAX_FRAMES);
		end else begin
			cap = OW'(fcnt_q);
		end
	end

	// associative search against valid entries
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match_d[i] = (OW'(i) < occ_q) && (rpage_q[i] == logical_page[PW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_q   <= logical_page[PW-1:0];
			match_s1 <= match_d;
		end
	end

	// update decode
	always_comb begin
		pos = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				pos = IW'(i);
			end
		end
		hit        = |match_s1;
		room       = occ_q < cap;
		rotate     = hit || !room;
		shift_from = hit ? pos : '0;
		last       = occ_q - OW'(1);
		if (hit) begin
			new_frame = rframe_q[pos];
		end else if (room) begin
			new_frame = faddr_q[FA_IW'(occ_q)];
		end else begin
			new_frame = rframe_q[0];
		end
	end

	// resident list reorder / append
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (rotate) begin
					if (OW'(i) == last) begin
						rpage_q[i]  <= page_q;
						rframe_q[i] <= new_frame;
					end else if (i < MAX_FRAMES - 1) begin
						if ((OW'(i) >= OW'(shift_from)) && (OW'(i) < last)) begin
							rpage_q[i]  <= rpage_q[i+1];
							rframe_q[i] <= rframe_q[i+1];
						end
					end
				end else if (OW'(i) == occ_q) begin
					rpage_q[i]  <= page_q;
					rframe_q[i] <= new_frame;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit && !rotate) begin
				occ_q <= occ_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			frame_q <= new_frame;
			hit_q   <= hit;
		end
	end

	assign done       = done_q;
	assign phys_frame = frame_q;
	assign was_hit    = hit_q;

	`LPFM_ASSERT(a_done_after_commit, clk, arst_n, done_q |-> $past(cmd.commit), "result strobe without commit")
	`LPFM_ASSERT(a_occ_bound, clk, arst_n, occ_q <= OW'(MAX_FRAMES), "occupancy above MAX_FRAMES")
	`LPFM_ASSERT(a_unique_match, clk, arst_n, cmd.commit |-> $onehot0(match_s1), "duplicate resident page")
	`LPFM_ASSERT_NEXT(a_append_grows, clk, arst_n, cmd.commit && !rotate, occ_q == $past(occ_q) + OW'(1), "append did not grow occupancy")
	`LPFM_ASSERT_NEXT(a_rotate_keeps_occ, clk, arst_n, cmd.commit && rotate, $stable(occ_q), "reorder changed occupancy")

endmodule
